// ===== design/rbe_pkg.sv =====
// ----------------------------------------------------------------------------
// rbe_pkg: shared definitions for the byte-wise rANS encoder
// Widths, the coder's lower bound, opcodes and the sequencer state type.
// ----------------------------------------------------------------------------
package rbe_pkg;

  localparam int STATE_W     = 32;
  localparam int FREQ_W      = 13;
  localparam int CUM_W       = 12;
  localparam int BYTE_W      = 8;
  localparam int PROB_BITS   = 12;
  localparam int LOWER_BITS  = 23;
  localparam logic [STATE_W-1:0] LOWER_BOUND = STATE_W'(1) << LOWER_BITS;

  localparam logic OP_ENCODE = 1'b0;
  localparam logic OP_FLUSH  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RENORM,
    ST_DIV,
    ST_UPDATE,
    ST_FLUSH
  } state_t;

endpackage

// ===== design/rbe_divider.sv =====
// ----------------------------------------------------------------------------
// rbe_divider: radix-2 restoring divider
// Produces one quotient bit per cycle with a single subtractor.
// ----------------------------------------------------------------------------
module rbe_divider #(
  parameter int DividendW = rbe_pkg::STATE_W,
  parameter int DivisorW  = rbe_pkg::FREQ_W
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [DividendW-1:0] dividend,
  input  logic [DivisorW-1:0]  divisor,
  output logic                 done,
  output logic [DividendW-1:0] quotient,
  output logic [DivisorW-1:0]  remainder
);

  localparam int CntW = $clog2(DividendW);

  logic                busy;
  logic [CntW-1:0]     step;
  logic [DividendW-1:0] quo;
  logic [DivisorW-1:0]  rem;
  logic [DivisorW:0]    rem_shift;
  logic [DivisorW+1:0]  diff;
  logic                 borrow;

  // The shifted remainder is below twice the divisor, so it fits one extra bit.
  assign rem_shift = {rem, quo[DividendW-1]};
  assign diff      = {1'b0, rem_shift} - {2'b00, divisor};
  assign borrow    = diff[DivisorW+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + CntW'(1);
        if (step == CntW'(DividendW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
    end else if (busy) begin
      quo <= {quo[DividendW-2:0], ~borrow};
      rem <= borrow ? rem_shift[DivisorW-1:0] : diff[DivisorW-1:0];
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule

// ===== design/rans_byte_encoder.sv =====
// ----------------------------------------------------------------------------
// rans_byte_encoder: byte-wise rANS encoder with a 32-bit state
// Encodes symbols from (cumulative frequency, frequency) pairs and flushes
// the final state as four bytes.
// ----------------------------------------------------------------------------
// An encode transaction is accepted, then emits its renormalisation bytes
// (zero to two, waiting while the output is stalled), tests for the end of
// renormalisation and starts the radix-2 divider, waits for the divider's
// result, and then updates the state. A flush transaction emits the four
// state bytes, waiting while the output is stalled. An encode with a zero
// frequency is accepted and ignored. The input is not ready while an item
// is in progress; the output byte sits in a register, so a finished byte
// may wait while the next item is accepted.
module rans_byte_encoder #(
  parameter int PROB_BITS = rbe_pkg::PROB_BITS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // cum_freq[11:0], sym_freq[24:12], zero fill
  input  logic        s_axis_tuser,  // opcode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // out_byte
  output logic        m_axis_tlast   // last byte of the transaction's results
);

  localparam int StateW      = rbe_pkg::STATE_W;
  localparam int FreqW       = rbe_pkg::FREQ_W;
  localparam int CumW        = rbe_pkg::CUM_W;
  localparam int ByteW       = rbe_pkg::BYTE_W;
  localparam int RenormShift = rbe_pkg::LOWER_BITS - PROB_BITS + ByteW;
  localparam logic [2:0] MaxRenorm = 3'd4;
  localparam logic [2:0] FlushLast = 3'd3;

  rbe_pkg::state_t st, st_next;

  logic [StateW-1:0] coder_state;
  logic [FreqW-1:0]  freq;
  logic [CumW-1:0]   cum;
  logic [2:0]        cnt;

  logic              accept;
  logic              out_free;
  logic              renorm_more;
  logic              renorm_after;
  logic [StateW-1:0] state_shifted;
  logic              emit;
  logic              emit_last;
  logic [ByteW-1:0]  emit_byte;
  logic              div_start;
  logic              div_done;
  logic [StateW-1:0] div_quo;
  logic [FreqW-1:0]  div_rem;
  logic [StateW-1:0] state_update;

  assign accept   = s_axis_tvalid & s_axis_tready;
  assign out_free = ~m_axis_tvalid | m_axis_tready;

  // state >= freq << shift holds exactly when (state >> shift) >= freq.
  assign state_shifted = coder_state >> ByteW;
  assign renorm_more   = ((coder_state >> RenormShift) >= StateW'(freq)) && (cnt < MaxRenorm);
  assign renorm_after  = ((state_shifted >> RenormShift) >= StateW'(freq))
                         && (cnt < MaxRenorm - 3'd1);

  assign state_update = (div_quo << PROB_BITS) + StateW'(cum) + StateW'(div_rem);

  rbe_divider #(
    .DividendW(StateW),
    .DivisorW (FreqW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (coder_state),
    .divisor  (freq),
    .done     (div_done),
    .quotient (div_quo),
    .remainder(div_rem)
  );

  always_comb begin
    st_next = st;
    unique case (st)
      rbe_pkg::ST_IDLE: begin
        if (accept) begin
          if (s_axis_tuser == rbe_pkg::OP_FLUSH) begin
            st_next = rbe_pkg::ST_FLUSH;
          end else if (s_axis_tdata[CumW +: FreqW] != '0) begin
            st_next = rbe_pkg::ST_RENORM;
          end
        end
      end
      rbe_pkg::ST_RENORM: begin
        if (!renorm_more) begin
          st_next = rbe_pkg::ST_DIV;
        end
      end
      rbe_pkg::ST_DIV: begin
        if (div_done) begin
          st_next = rbe_pkg::ST_UPDATE;
        end
      end
      rbe_pkg::ST_UPDATE: begin
        st_next = rbe_pkg::ST_IDLE;
      end
      rbe_pkg::ST_FLUSH: begin
        if (out_free && cnt == FlushLast) begin
          st_next = rbe_pkg::ST_IDLE;
        end
      end
      default: st_next = rbe_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    emit          = 1'b0;
    emit_last     = 1'b0;
    emit_byte     = coder_state[ByteW-1:0];
    div_start     = 1'b0;
    unique case (st)
      rbe_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
      end
      rbe_pkg::ST_RENORM: begin
        emit      = renorm_more & out_free;
        emit_last = ~renorm_after;
        div_start = ~renorm_more;
      end
      rbe_pkg::ST_FLUSH: begin
        emit      = out_free;
        emit_last = (cnt == FlushLast);
        emit_byte = coder_state[StateW-1 -: ByteW];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st            <= rbe_pkg::ST_IDLE;
      coder_state   <= rbe_pkg::LOWER_BOUND;
      cnt           <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      st <= st_next;

      if (emit) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end

      unique case (st)
        rbe_pkg::ST_IDLE: begin
          cnt <= '0;
        end
        rbe_pkg::ST_RENORM: begin
          if (emit) begin
            coder_state <= state_shifted;
            cnt         <= cnt + 3'd1;
          end
        end
        rbe_pkg::ST_UPDATE: begin
          coder_state <= state_update;
        end
        rbe_pkg::ST_FLUSH: begin
          if (emit) begin
            cnt <= cnt + 3'd1;
            // Bytes leave most significant first; the final one restarts the coder.
            if (cnt == FlushLast) begin
              coder_state <= rbe_pkg::LOWER_BOUND;
            end else begin
              coder_state <= coder_state << ByteW;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cum  <= s_axis_tdata[CumW-1:0];
      freq <= s_axis_tdata[CumW +: FreqW];
    end
    if (emit) begin
      m_axis_tdata <= emit_byte;
      m_axis_tlast <= emit_last;
    end
  end

endmodule
